/* rtl/core/text_stream_visible_filter_assert.svh */
// assertion macros used by the checker file
`ifndef TEXT_STREAM_VISIBLE_FILTER_ASSERT_SVH
`define TEXT_STREAM_VISIBLE_FILTER_ASSERT_SVH

// same-cycle implication, masked while reset is high
`define TSVF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked while reset is high
`define TSVF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define TSVF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/tsvf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tsvf_pkg;

   // control register indexes on the csr port
   localparam logic [2:0] CSR_NUMBER_NONBLANK  = 3'd0;
   localparam logic [2:0] CSR_NUMBER_ALL       = 3'd1;
   localparam logic [2:0] CSR_SQUASH_BLANK     = 3'd2;
   localparam logic [2:0] CSR_MARK_LINE_END    = 3'd3;
   localparam logic [2:0] CSR_CARET_TAB        = 3'd4;
   localparam logic [2:0] CSR_SHOW_NONPRINTING = 3'd5;

   // character codes
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_NL     = 8'h0A;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_DOLLAR = 8'h24;
   localparam logic [7:0] CHR_DASH   = 8'h2D;
   localparam logic [7:0] CHR_QMARK  = 8'h3F;
   localparam logic [7:0] CHR_CTRL   = 8'h40;
   localparam logic [7:0] CHR_I      = 8'h49;
   localparam logic [7:0] CHR_M      = 8'h4D;
   localparam logic [7:0] CHR_CARET  = 8'h5E;
   localparam logic [6:0] CHR_DEL    = 7'h7F;
   localparam logic [3:0] DIGIT_HI   = 4'h3;
   localparam logic [3:0] BCD_NINE   = 4'd9;

   typedef struct packed {
      logic number_nonblank;
      logic number_all;
      logic squash_blank;
      logic mark_line_end;
      logic caret_tab;
      logic show_nonprinting;
   } tsvf_cfg_type;

   // classified request: optional number prefix plus up to four body bytes
   typedef struct packed {
      logic            numbered;
      logic [1:0]      last_idx;
      logic [3:0][7:0] chars;
   } tsvf_body_type;

endpackage

`default_nettype wire

/* rtl/core/tsvf_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsvf_front #(
   parameter int COUNT_DIGITS = 10
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire tsvf_pkg::tsvf_cfg_type cfg,
   input  wire                        req_valid,
   input  wire                        req_stall,
   input  wire  [7:0]                 req_in_byte,
   input  wire                        req_file_start,
   output logic                       push,
   output tsvf_pkg::tsvf_body_type    push_body,
   output logic [4*COUNT_DIGITS-1:0]  push_digits
);
   import tsvf_pkg::*;

   localparam int NUM_W = 4 * COUNT_DIGITS;

   logic             prev_nl_ff, prev_nl_in;
   logic             squeezing_ff, squeezing_in;
   logic [NUM_W-1:0] line_num_ff, line_num_in;

   logic             accept, nl;
   logic             eff_prev, eff_sq, sq_keep, drop, do_num;
   logic [NUM_W-1:0] eff_num, num_inc;
   logic             carry;
   logic [3:0]       dig;
   logic [6:0]       low7;
   logic [7:0]       t0, t1;
   logic             two;
   tsvf_body_type    body;

   assign accept = req_valid && !req_stall;
   assign nl     = (req_in_byte == CHR_NL);

   // file start puts the line state back to its reset values first
   assign eff_prev = req_file_start ? 1'b1 : prev_nl_ff;
   assign eff_sq   = req_file_start ? 1'b0 : squeezing_ff;
   assign eff_num  = req_file_start ? '0 : line_num_ff;

   // squeeze handling: a newline right after a squeezed blank line is dropped
   assign sq_keep = cfg.squash_blank && nl && eff_sq;
   assign drop    = cfg.squash_blank && nl && eff_prev && sq_keep;
   assign do_num  = eff_prev && (cfg.number_nonblank ? !nl : cfg.number_all);

   // bcd increment, wraps to zero after all nines
   always_comb begin
      carry   = 1'b1;
      num_inc = eff_num;
      dig     = '0;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         dig = eff_num[4*i +: 4];
         if (carry) begin
            num_inc[4*i +: 4] = (dig == BCD_NINE) ? 4'd0 : dig + 4'd1;
         end
         carry = carry && (dig == BCD_NINE);
      end
   end

   // caret form of the low seven bits
   assign low7 = req_in_byte[6:0];
   always_comb begin
      if (low7 < 7'd32) begin
         t0  = CHR_CARET;
         t1  = {1'b0, low7} + CHR_CTRL;
         two = 1'b1;
      end else if (low7 == CHR_DEL) begin
         t0  = CHR_CARET;
         t1  = CHR_QMARK;
         two = 1'b1;
      end else begin
         t0  = {1'b0, low7};
         t1  = {1'b0, low7};
         two = 1'b0;
      end
   end

   // body bytes of the request
   always_comb begin
      body          = '0;
      body.numbered = do_num;
      body.chars    = {4{req_in_byte}};
      body.last_idx = 2'd0;
      if (nl) begin
         if (cfg.mark_line_end) begin
            body.chars[0] = CHR_DOLLAR;
            body.chars[1] = CHR_NL;
            body.last_idx = 2'd1;
         end
      end else if (req_in_byte == CHR_TAB) begin
         if (cfg.caret_tab) begin
            body.chars[0] = CHR_CARET;
            body.chars[1] = CHR_I;
            body.last_idx = 2'd1;
         end
      end else if (cfg.show_nonprinting) begin
         if (req_in_byte[7]) begin
            body.chars[0] = CHR_M;
            body.chars[1] = CHR_DASH;
            body.chars[2] = t0;
            body.chars[3] = t1;
            body.last_idx = two ? 2'd3 : 2'd2;
         end else begin
            body.chars[0] = t0;
            body.chars[1] = t1;
            body.last_idx = two ? 2'd1 : 2'd0;
         end
      end
   end

   // next line state
   always_comb begin
      prev_nl_in   = prev_nl_ff;
      squeezing_in = squeezing_ff;
      line_num_in  = line_num_ff;
      if (accept && !drop) begin
         prev_nl_in   = nl;
         squeezing_in = (cfg.squash_blank && nl && eff_prev) ? 1'b1 : sq_keep;
         line_num_in  = do_num ? num_inc : eff_num;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_nl_ff   <= 1'b1;
         squeezing_ff <= 1'b0;
         line_num_ff  <= '0;
      end else begin
         prev_nl_ff   <= prev_nl_in;
         squeezing_ff <= squeezing_in;
         line_num_ff  <= line_num_in;
      end
   end

   assign push        = accept && !drop;
   assign push_body   = body;
   assign push_digits = do_num ? num_inc : eff_num;

endmodule

`default_nettype wire

/* rtl/core/tsvf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsvf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire  [WIDTH-1:0] push_data,
   input  wire              pop,
   output logic             full,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* rtl/core/tsvf_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsvf_back #(
   parameter int COUNT_DIGITS = 10,
   parameter int PAD_WIDTH    = 6
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        head_valid,
   input  wire tsvf_pkg::tsvf_body_type head_body,
   input  wire  [4*COUNT_DIGITS-1:0]  head_digits,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last_of_run
);
   import tsvf_pkg::*;

   localparam int NUM_W    = 4 * COUNT_DIGITS;
   localparam int NUM_MAX  = (COUNT_DIGITS > PAD_WIDTH) ? COUNT_DIGITS : PAD_WIDTH;
   localparam int LAST_MAX = NUM_MAX + 4;
   localparam int POS_W    = $clog2(LAST_MAX + 1);

   logic             cur_valid_ff, cur_valid_in;
   tsvf_body_type    cur_body_ff, cur_body_in;
   logic [NUM_W-1:0] cur_digits_ff, cur_digits_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;

   logic [POS_W-1:0] sig, num_len, pre_len, last_pos, dig_pos, body_pos;
   logic [3:0]       dig;
   logic [7:0]       ch;
   logic             is_last, advance, load;

   // count of significant digits, at least one
   always_comb begin
      sig = POS_W'(1);
      for (int i = 1; i < COUNT_DIGITS; i++) begin
         if (cur_digits_ff[4*i +: 4] != 4'd0) begin
            sig = POS_W'(i + 1);
         end
      end
   end

   assign num_len  = (sig > POS_W'(PAD_WIDTH)) ? sig : POS_W'(PAD_WIDTH);
   assign pre_len  = cur_body_ff.numbered ? num_len + 1'b1 : '0;
   assign last_pos = pre_len + POS_W'(cur_body_ff.last_idx);
   assign is_last  = (pos_ff == last_pos);
   assign dig_pos  = num_len - 1'b1 - pos_ff;
   assign body_pos = pos_ff - pre_len;

   // digit under the current column
   always_comb begin
      dig = '0;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (dig_pos == POS_W'(i)) begin
            dig = cur_digits_ff[4*i +: 4];
         end
      end
   end

   // character at the current position of the run
   always_comb begin
      if (pos_ff < pre_len) begin
         if (pos_ff == num_len) begin
            ch = CHR_TAB;
         end else if (dig_pos >= sig) begin
            ch = CHR_SPACE;
         end else begin
            ch = {DIGIT_HI, dig};
         end
      end else begin
         ch = cur_body_ff.chars[body_pos[1:0]];
      end
   end

   // run sequencing: refill from the queue as the last byte leaves
   assign advance = !out_valid_ff || !rsp_stall;
   assign load    = !cur_valid_ff || (advance && is_last);
   assign pop     = load && head_valid;

   always_comb begin
      cur_valid_in  = cur_valid_ff;
      cur_body_in   = cur_body_ff;
      cur_digits_in = cur_digits_ff;
      pos_in        = pos_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      if (advance) begin
         out_valid_in = cur_valid_ff;
         out_byte_in  = ch;
         out_last_in  = is_last;
      end
      if (load) begin
         cur_valid_in  = head_valid;
         cur_body_in   = head_body;
         cur_digits_in = head_digits;
         pos_in        = '0;
      end else if (advance) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_body_ff   <= cur_body_in;
      cur_digits_ff <= cur_digits_in;
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

`default_nettype wire

/* rtl/core/text_stream_visible_filter.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake            | payload
// --------+----------------------+-------------------------------------
// req     | req_valid, req_stall | req_in_byte[7:0], req_file_start
// rsp     | rsp_valid, rsp_stall | rsp_out_byte[7:0], rsp_last_of_run
// csr     | csr_valid, csr_ready | csr_index[2:0], csr_wdata
//
// a request is classified in the cycle it is taken; the back end sends one
// byte per cycle unless rsp_stall is high; a request producing n bytes (1 to 15)
// occupies the output for all n; single-byte requests stream at one per cycle
// the four-entry queue between front and back sets how far the input runs ahead
// reset is synchronous; csr_ready is always high, option registers clear to zero
// rsp_stall holds the output register; req_stall rises only when the queue is full

module text_stream_visible_filter #(
   parameter int COUNT_DIGITS = 10,
   parameter int PAD_WIDTH    = 6
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [7:0] req_in_byte,
   input  wire        req_file_start,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire  [2:0] csr_index,
   input  wire        csr_wdata
);
   import tsvf_pkg::*;

   localparam int NUM_W    = 4 * COUNT_DIGITS;
   localparam int BODY_W   = $bits(tsvf_body_type);
   localparam int ENTRY_W  = BODY_W + NUM_W;
   localparam int Q_DEPTH  = 4;

   tsvf_cfg_type     cfg_ff, cfg_in;
   logic             push, pop, q_full, head_valid;
   tsvf_body_type    push_body, head_body;
   logic [NUM_W-1:0] push_digits, head_digits;
   logic [ENTRY_W-1:0] head_entry;

   // control registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NUMBER_NONBLANK:  cfg_in.number_nonblank  = csr_wdata;
            CSR_NUMBER_ALL:       cfg_in.number_all       = csr_wdata;
            CSR_SQUASH_BLANK:     cfg_in.squash_blank     = csr_wdata;
            CSR_MARK_LINE_END:    cfg_in.mark_line_end    = csr_wdata;
            CSR_CARET_TAB:        cfg_in.caret_tab        = csr_wdata;
            CSR_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;

   // front: line state and classification
   tsvf_front #(
      .COUNT_DIGITS (COUNT_DIGITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_file_start (req_file_start),
      .push           (push),
      .push_body      (push_body),
      .push_digits    (push_digits)
   );

   // queue between classification and output sequencing
   tsvf_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_body, push_digits}),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_data  (head_entry)
   );

   assign head_body   = head_entry[ENTRY_W-1 -: BODY_W];
   assign head_digits = head_entry[NUM_W-1:0];

   // back: one output byte per cycle while rsp_stall is low
   tsvf_back #(
      .COUNT_DIGITS (COUNT_DIGITS),
      .PAD_WIDTH    (PAD_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_body       (head_body),
      .head_digits     (head_digits),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

/* rtl/core/tsvf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "text_stream_visible_filter_assert.svh"

module tsvf_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_stall,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire [7:0] rsp_out_byte,
   input wire       rsp_last_of_run
);
   import tsvf_pkg::*;

   // a stalled response stays in place
   `TSVF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_of_run), "stalled response changed")

   // output and queue come out of reset empty
   `TSVF_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall, "not empty after reset")

   // a newline only ever closes a run
   `TSVF_ASSERT_IMPLY(a_nl_last, clock, reset, rsp_valid && rsp_out_byte == CHR_NL, rsp_last_of_run, "newline inside a run")

   // an end marker is followed right away by its newline
   `TSVF_ASSERT_NEXT(a_end_mark, clock, reset, rsp_valid && !rsp_stall && rsp_out_byte == CHR_DOLLAR && !rsp_last_of_run, rsp_valid && rsp_out_byte == CHR_NL, "end marker without newline")

endmodule

bind text_stream_visible_filter tsvf_checker u_tsvf_checker (.*);

`default_nettype wire

/* test/text_stream_visible_filter_test.sv */
`timescale 1ns / 1ps

module text_stream_visible_filter_test;
   import tsvf_pkg::*;

   localparam int COUNT_DIGITS = 10;
   localparam int PAD_WIDTH    = 6;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 30;
   localparam int LONG_HOLD    = 300;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 20;

   // indexes the block has no register for, writes there must be ignored
   localparam logic [2:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [2:0] CSR_UNUSED_HI = 3'd7;

   // directed text, first byte in the top slot
   localparam int DIRECTED_LEN = 22;
   localparam int DIRECTED_FILE_START = 3;
   localparam logic [DIRECTED_LEN-1:0][7:0] DIRECTED_TEXT = {
      8'h41, CHR_TAB, CHR_NL, CHR_NL, CHR_NL, CHR_NL, 8'h00, 8'h1F,
      CHR_SPACE, 8'h7E, 8'h7F, 8'h80, 8'h89, 8'h8A, 8'h9F, 8'hA0,
      8'hFF, CHR_NL, CHR_NL, CHR_NL, 8'h7A, CHR_NL};

   typedef struct packed {
      logic [7:0] ch;
      logic       fs;
   } text_req_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } shown_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   wire        req_stall;
   logic [7:0] req_in_byte = '0;
   logic       req_file_start = 1'b0;
   wire        rsp_valid;
   logic       rsp_stall = 1'b0;
   wire  [7:0] rsp_out_byte;
   wire        rsp_last_of_run;
   logic       csr_valid = 1'b0;
   wire        csr_ready;
   logic [2:0] csr_index = '0;
   logic       csr_wdata = 1'b0;

   text_stream_visible_filter #(
      .COUNT_DIGITS(COUNT_DIGITS),
      .PAD_WIDTH(PAD_WIDTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_byte(req_in_byte),
      .req_file_start(req_file_start),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // shadow copy of the filter state and options
   tsvf_cfg_type                opts = '0;
   logic                        at_line_start = 1'b1;
   logic                        squeezing = 1'b0;
   logic [4*COUNT_DIGITS-1:0]   line_bcd = '0;

   text_req_type   text_backlog [$];
   shown_char_type shown_chars_due [$];

   int unsigned items_queued = 0;
   int unsigned items_taken = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   logic        req_fired = 1'b0;
   logic        calm = 1'b0;
   int          send_gap = 0;
   int          stall_gap = 0;
   int          hold_left = 0;
   int          long_hold_asks = 0;
   int          long_hold_seen = 0;

   // expected visible characters for one request
   function automatic void render_byte(input logic [7:0] ch, input logic fs);
      logic [7:0]     run [$];
      logic           nl;
      logic           carry;
      logic [6:0]     low;
      int             sig;
      int             i;
      shown_char_type item;
      nl = (ch == CHR_NL);
      if (fs) begin
         line_bcd = '0;
         at_line_start = 1'b1;
         squeezing = 1'b0;
      end
      if (!opts.squash_blank || !nl)
         squeezing = 1'b0;
      // repeated blank line while squeezing is dropped
      if (opts.squash_blank && nl && at_line_start) begin
         if (squeezing)
            return;
         squeezing = 1'b1;
      end
      // line number prefix, bcd increment then right-aligned digits and tab
      if (at_line_start && (opts.number_nonblank ? !nl : opts.number_all)) begin
         carry = 1'b1;
         for (i = 0; i < COUNT_DIGITS; i++) begin
            if (carry) begin
               if (line_bcd[4*i +: 4] == BCD_NINE) begin
                  line_bcd[4*i +: 4] = '0;
               end else begin
                  line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
                  carry = 1'b0;
               end
            end
         end
         sig = 1;
         for (i = COUNT_DIGITS - 1; i > 0; i--)
            if (sig == 1 && line_bcd[4*i +: 4] != 4'd0)
               sig = i + 1;
         for (i = sig; i < PAD_WIDTH; i++)
            run.push_back(CHR_SPACE);
         for (i = sig - 1; i >= 0; i--)
            run.push_back({DIGIT_HI, line_bcd[4*i +: 4]});
         run.push_back(CHR_TAB);
      end
      // body of the character
      if (nl) begin
         if (opts.mark_line_end)
            run.push_back(CHR_DOLLAR);
         run.push_back(ch);
      end else if (ch == CHR_TAB) begin
         if (opts.caret_tab) begin
            run.push_back(CHR_CARET);
            run.push_back(CHR_I);
         end else begin
            run.push_back(ch);
         end
      end else if (opts.show_nonprinting) begin
         low = ch[6:0];
         if (ch[7]) begin
            run.push_back(CHR_M);
            run.push_back(CHR_DASH);
         end
         if (low < 7'd32) begin
            run.push_back(CHR_CARET);
            run.push_back({1'b0, low} + CHR_CTRL);
         end else if (low == CHR_DEL) begin
            run.push_back(CHR_CARET);
            run.push_back(CHR_QMARK);
         end else begin
            run.push_back({1'b0, low});
         end
      end else begin
         run.push_back(ch);
      end
      at_line_start = nl;
      for (i = 0; i < run.size(); i++) begin
         item.ch = run[i];
         item.last = (i == run.size() - 1);
         shown_chars_due.push_back(item);
      end
   endfunction

   // option register write seen by the block
   function automatic void apply_option(input logic [2:0] idx, input logic d);
      case (idx)
         CSR_NUMBER_NONBLANK:  opts.number_nonblank = d;
         CSR_NUMBER_ALL:       opts.number_all = d;
         CSR_SQUASH_BLANK:     opts.squash_blank = d;
         CSR_MARK_LINE_END:    opts.mark_line_end = d;
         CSR_CARET_TAB:        opts.caret_tab = d;
         CSR_SHOW_NONPRINTING: opts.show_nonprinting = d;
         default: ;
      endcase
   endfunction

   // watchdog, request prediction and output checking
   always @(posedge clock) begin
      shown_char_type want;
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else if (reset) begin
         req_fired <= 1'b0;
      end else begin
         if (csr_valid && csr_ready)
            apply_option(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            render_byte(req_in_byte, req_file_start);
            items_taken <= items_taken + 1;
            req_fired <= 1'b1;
         end else begin
            req_fired <= 1'b0;
         end
         if (rsp_valid && !rsp_stall) begin
            if (shown_chars_due.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected output %02h last %0b at cycle %0d",
                           rsp_out_byte, rsp_last_of_run, cycle_count);
               mismatches = mismatches + 1;
            end else begin
               want = shown_chars_due.pop_front();
               if (rsp_out_byte !== want.ch || rsp_last_of_run !== want.last) begin
                  if (mismatches < 10)
                     $display("mismatch at cycle %0d: expected %02h last %0b, got %02h last %0b",
                              cycle_count, want.ch, want.last, rsp_out_byte,
                              rsp_last_of_run);
                  mismatches = mismatches + 1;
               end
            end
         end
      end
   end

   // request driver, holds a request until it is taken
   always @(negedge clock) begin
      text_req_type nxt;
      logic         v;
      v = req_valid;
      if (!req_valid || req_fired) begin
         v = 1'b0;
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
         end else if (text_backlog.size() > 0) begin
            if (!calm && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 14) - 1;
            end else begin
               nxt = text_backlog.pop_front();
               req_in_byte <= nxt.ch;
               req_file_start <= nxt.fs;
               v = 1'b1;
            end
         end
      end
      req_valid <= v;
   end

   // output stall, random bursts plus an occasional long hold-off
   always @(negedge clock) begin
      logic s;
      if (long_hold_asks != long_hold_seen) begin
         long_hold_seen = long_hold_asks;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         s = 1'b1;
      end else if (stall_gap > 0) begin
         stall_gap = stall_gap - 1;
         s = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_gap = $urandom_range(1, 14) - 1;
         s = 1'b1;
      end else begin
         s = 1'b0;
      end
      rsp_stall <= s;
   end

   task automatic queue_text(input logic [7:0] ch, input logic fs);
      text_req_type it;
      it.ch = ch;
      it.fs = fs;
      text_backlog.push_back(it);
      items_queued = items_queued + 1;
   endtask

   // text-like content: lines, blank runs, tabs, control and high bytes
   task automatic add_random_text(input int n);
      int         k;
      int         r;
      int         run;
      logic       fs;
      logic [7:0] ch;
      for (k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         fs = ($urandom_range(0, 39) == 0);
         if (r < 14) begin
            run = $urandom_range(1, 4);
            repeat (run) begin
               queue_text(CHR_NL, fs);
               fs = 1'b0;
            end
         end else begin
            if (r < 22)
               ch = CHR_TAB;
            else if (r < 32)
               ch = $urandom_range(0, 31);
            else if (r < 38)
               ch = ($urandom_range(0, 3) == 0) ? 8'h7F : 8'($urandom_range(128, 159));
            else if (r < 50)
               ch = $urandom_range(0, 255);
            else
               ch = $urandom_range(32, 126);
            queue_text(ch, fs);
         end
      end
   endtask

   // wait until every request is taken and every character has come out
   task automatic wait_drained();
      while (items_taken != items_queued || shown_chars_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic write_reg(input logic [2:0] idx, input logic d);
      csr_index <= idx;
      csr_wdata <= d;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic set_options(input tsvf_cfg_type o);
      write_reg(CSR_NUMBER_NONBLANK, o.number_nonblank);
      write_reg(CSR_NUMBER_ALL, o.number_all);
      write_reg(CSR_SQUASH_BLANK, o.squash_blank);
      write_reg(CSR_MARK_LINE_END, o.mark_line_end);
      write_reg(CSR_CARET_TAB, o.caret_tab);
      write_reg(CSR_SHOW_NONPRINTING, o.show_nonprinting);
      csr_valid <= 1'b0;
   endtask

   initial begin
      tsvf_cfg_type o;
      int           p;
      int           i;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: all displays on, every line numbered, squeeze on
      write_reg(CSR_UNUSED_LO, 1'b1);
      write_reg(CSR_UNUSED_HI, 1'b1);
      o = '0;
      o.number_all = 1'b1;
      o.squash_blank = 1'b1;
      o.mark_line_end = 1'b1;
      o.caret_tab = 1'b1;
      o.show_nonprinting = 1'b1;
      set_options(o);
      for (i = DIRECTED_LEN - 1; i >= 0; i--)
         queue_text(DIRECTED_TEXT[i], i == DIRECTED_FILE_START);
      wait_drained();

      // random phases, option extremes first
      for (p = 0; p < PHASES; p++) begin
         if (p == 0)
            o = '1;
         else if (p == 1)
            o = '0;
         else
            o = tsvf_cfg_type'(6'($urandom_range(0, 63)));
         set_options(o);
         if (p == PHASES - 1)
            calm = 1'b1;
         add_random_text(PHASE_ITEMS);
         if (p == 2)
            long_hold_asks = long_hold_asks + 1;
         wait_drained();
      end

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
